>>> rtl/ghtc_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the gyro heading and turn controller.
// Used by ghtc_ctrl, ghtc_dp and gyro_heading_turn_controller_top; no dependencies.
package ghtc_pkg;

  // Turn sequence constants.
  localparam int unsigned MAX_PULSES    = 8;
  localparam int unsigned PULSE_MS      = 80;
  localparam int unsigned TURN_STEP_DEG = 90;

  localparam logic [31:0] PULSE_US  = 32'(PULSE_MS * 1000);
  localparam logic [31:0] HALF_TURN = 32'h8000_0000;
  localparam logic [63:0] STEP_WIDE = ((64'(TURN_STEP_DEG) << 32) + 64'd180) / 64'd360;
  localparam logic [31:0] TURN_STEP = STEP_WIDE[31:0];
  localparam logic [3:0]  MAX_PULSE_CNT = 4'(MAX_PULSES);

  // round(2^56 / (131 * 360e6)), turns raw rate times microseconds into turn units.
  localparam logic signed [21:0] GYRO_K = 22'sd1527939;

  // Configuration port.
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 31;

  localparam logic [CFG_IDX_W-1:0] CFG_GYRO_BIAS   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEADBAND    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TURN_SPEED  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CORR_SPEED  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_STOP_MARGIN = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_BRAKE_ZONE  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_MS  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SETTLE_MS   = 3'd7;

  // Operation codes of an input word.
  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_RIGHT = 2'd1;
  localparam logic [1:0] OP_LEFT  = 2'd2;
  localparam logic [1:0] OP_NORTH = 2'd3;

  typedef enum logic [1:0] {
    S_IDLE,
    S_MUL,
    S_HEAD,
    S_STEP
  } seq_state_t;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_SPIN,
    PH_SETTLE,
    PH_PULSE,
    PH_FINAL
  } phase_t;

  typedef enum logic [1:0] {
    DRV_OFF,
    DRV_SPIN,
    DRV_CORR
  } drive_t;

  typedef struct packed {
    logic   accept;
    logic   mul_en;
    logic   head_en;
    logic   north;
    logic   turn_start;
    logic   turn_right;
    logic   time_add;
    logic   time_clear;
    logic   load_out;
    drive_t drive;
    logic   drive_half;
    logic   drive_right;
    logic   busy_out;
    logic   done_out;
    logic   timeout_out;
  } dp_cmd_t;

  typedef struct packed {
    logic spin_stop;
    logic spin_brake;
    logic spin_timeout;
    logic settle_elapsed;
    logic pulse_elapsed;
    logic err_ok;
    logic err_pos;
  } dp_status_t;

endpackage

>>> rtl/ghtc_dp.sv
`timescale 1ns / 1ps
// Datapath: configuration registers, heading integration, target, phase timer,
// comparisons and the output word register. Depends on ghtc_pkg.
module ghtc_dp (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [ghtc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ghtc_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic signed [15:0]               gyro_z,
  input  logic [15:0]                      dt_us,
  input  ghtc_pkg::dp_cmd_t                cmd,
  output ghtc_pkg::dp_status_t             status,
  output logic signed [8:0]                left_drive,
  output logic signed [8:0]                right_drive,
  output logic [31:0]                      heading,
  output logic signed [31:0]               turn_error,
  output logic                             busy_res,
  output logic                             turn_done,
  output logic                             timed_out
);
  import ghtc_pkg::*;

  // Configuration; the millisecond times are kept in microseconds.
  logic signed [15:0] gyro_bias;
  logic [14:0]        deadband_raw;
  logic [7:0]         turn_speed;
  logic [7:0]         correction_speed;
  logic [30:0]        stop_margin;
  logic [30:0]        brake_zone;
  logic [25:0]        timeout_us;
  logic [25:0]        settle_us;

  logic [31:0]        heading_acc;
  logic [31:0]        target_angle;
  logic [31:0]        phase_time_us;
  logic [15:0]        dt;
  logic               skip;
  logic signed [33:0] prod1;
  logic signed [55:0] prod2;

  logic signed [16:0] corr;
  logic [16:0]        corr_mag;
  logic signed [16:0] dt_s;
  logic [32:0]        time_sum;
  logic [31:0]        err;
  logic [31:0]        err_neg;
  logic [31:0]        rem;
  logic [7:0]         speed;
  logic signed [8:0]  ld;

  always_ff @(posedge clk) begin
    if (rst) begin
      gyro_bias        <= '0;
      deadband_raw     <= 15'd131;
      turn_speed       <= 8'd120;
      correction_speed <= 8'd60;
      stop_margin      <= 31'd23860929;
      brake_zone       <= 31'd238609294;
      timeout_us       <= 26'd4000000;
      settle_us        <= 26'd150000;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_GYRO_BIAS:   gyro_bias        <= cfg_data[15:0];
        CFG_DEADBAND:    deadband_raw     <= cfg_data[14:0];
        CFG_TURN_SPEED:  turn_speed       <= cfg_data[7:0];
        CFG_CORR_SPEED:  correction_speed <= cfg_data[7:0];
        CFG_STOP_MARGIN: stop_margin      <= cfg_data[30:0];
        CFG_BRAKE_ZONE:  brake_zone       <= cfg_data[30:0];
        CFG_TIMEOUT_MS:  timeout_us       <= 26'(cfg_data[15:0] * 26'd1000);
        CFG_SETTLE_MS:   settle_us        <= 26'(cfg_data[15:0] * 26'd1000);
        default: ;
      endcase
    end
  end

  // First product is formed on the accept cycle, straight from the ports.
  assign corr     = 17'(gyro_z) - 17'(gyro_bias);
  assign corr_mag = corr[16] ? 17'(-corr) : 17'(corr);
  assign dt_s     = {1'b0, dt_us};

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      prod1 <= corr * dt_s;
      dt    <= dt_us;
      skip  <= corr_mag < {2'b00, deadband_raw};
    end
    if (cmd.mul_en) begin
      prod2 <= prod1 * GYRO_K;
    end
  end

  assign time_sum = {1'b0, phase_time_us} + 33'(dt);

  always_ff @(posedge clk) begin
    if (rst) begin
      heading_acc   <= '0;
      target_angle  <= '0;
      phase_time_us <= '0;
    end else begin
      if (cmd.head_en) begin
        // The increment is the product shifted down by 24 with floor rounding.
        if (cmd.north) begin
          heading_acc  <= '0;
          target_angle <= '0;
        end else begin
          if (!skip) begin
            heading_acc <= heading_acc + prod2[55:24];
          end
          if (cmd.turn_start) begin
            target_angle <= cmd.turn_right ? target_angle - TURN_STEP
                                           : target_angle + TURN_STEP;
          end
        end
      end
      if (cmd.time_clear) begin
        phase_time_us <= '0;
      end else if (cmd.time_add) begin
        phase_time_us <= time_sum[32] ? 32'hFFFF_FFFF : time_sum[31:0];
      end
    end
  end

  assign err     = target_angle - heading_acc;
  assign err_neg = heading_acc - target_angle;
  assign rem     = cmd.turn_right ? err_neg : err;

  always_comb begin
    status.spin_stop      = (rem <= {1'b0, stop_margin}) || (rem > HALF_TURN);
    status.spin_brake     = rem <= {1'b0, brake_zone};
    status.spin_timeout   = phase_time_us > {6'b0, timeout_us};
    status.settle_elapsed = phase_time_us >= {6'b0, settle_us};
    status.pulse_elapsed  = phase_time_us >= PULSE_US;
    status.err_ok         = (err <= {1'b0, stop_margin}) || (err_neg <= {1'b0, stop_margin});
    status.err_pos        = (err != '0) && (err <= HALF_TURN);
  end

  always_comb begin
    case (cmd.drive)
      DRV_SPIN: speed = cmd.drive_half ? {1'b0, turn_speed[7:1]} : turn_speed;
      DRV_CORR: speed = correction_speed;
      default:  speed = '0;
    endcase
    ld = cmd.drive_right ? $signed({1'b0, speed}) : -$signed({1'b0, speed});
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      left_drive  <= ld;
      right_drive <= -ld;
      heading     <= heading_acc;
      turn_error  <= err;
      busy_res    <= cmd.busy_out;
      turn_done   <= cmd.done_out;
      timed_out   <= cmd.timeout_out;
    end
  end

endmodule

>>> rtl/ghtc_ctrl.sv
`timescale 1ns / 1ps
// Controller: word sequencing state machine, output handshake and the turn
// sequencer (phase, direction, braking, pulse count). Depends on ghtc_pkg.
module ghtc_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [1:0]           op,
  output logic                 out_valid,
  input  logic                 out_ready,
  input  ghtc_pkg::dp_status_t status,
  output ghtc_pkg::dp_cmd_t    cmd
);
  import ghtc_pkg::*;

  seq_state_t state, state_next;
  phase_t     phase, phase_next;
  logic [1:0] op_r;
  logic       turn_right, turn_right_next;
  logic       braking, braking_next;
  logic [3:0] pulses_done, pulses_done_next;
  logic       timeout_seen, timeout_seen_next;

  logic busy;
  logic step_go;
  logic start;

  assign in_ready = (state == S_IDLE);
  assign busy     = (phase != PH_IDLE);
  assign step_go  = (state == S_STEP) && (!out_valid || out_ready);
  assign start    = !busy && ((op_r == OP_RIGHT) || (op_r == OP_LEFT));

  always_comb begin
    case (state)
      S_IDLE:  state_next = (in_valid) ? S_MUL : S_IDLE;
      S_MUL:   state_next = S_HEAD;
      S_HEAD:  state_next = S_STEP;
      S_STEP:  state_next = step_go ? S_IDLE : S_STEP;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    phase_next        = phase;
    turn_right_next   = turn_right;
    braking_next      = braking;
    pulses_done_next  = pulses_done;
    timeout_seen_next = timeout_seen;

    cmd             = '0;
    cmd.drive       = DRV_OFF;
    cmd.accept      = (state == S_IDLE) && in_valid;
    cmd.mul_en      = (state == S_MUL);
    cmd.turn_right  = turn_right;

    if (state == S_HEAD) begin
      cmd.head_en = 1'b1;
      cmd.north   = !busy && (op_r == OP_NORTH);
      if (start) begin
        cmd.turn_start    = 1'b1;
        cmd.turn_right    = (op_r == OP_RIGHT);
        cmd.time_clear    = 1'b1;
        turn_right_next   = (op_r == OP_RIGHT);
        braking_next      = 1'b0;
        pulses_done_next  = '0;
        timeout_seen_next = 1'b0;
        phase_next        = PH_SPIN;
      end else begin
        cmd.time_add = busy;
      end
    end

    if (step_go) begin
      cmd.load_out = 1'b1;
      case (phase)
        PH_SPIN: begin
          if (status.spin_stop) begin
            phase_next     = PH_SETTLE;
            cmd.time_clear = 1'b1;
          end else if (status.spin_timeout) begin
            timeout_seen_next = 1'b1;
            phase_next        = PH_SETTLE;
            cmd.time_clear    = 1'b1;
          end else begin
            // Braking latches for the rest of the spin once inside the zone.
            braking_next    = braking || status.spin_brake;
            cmd.drive       = DRV_SPIN;
            cmd.drive_half  = braking_next;
            cmd.drive_right = turn_right;
          end
        end
        PH_SETTLE: begin
          if (status.settle_elapsed) begin
            cmd.time_clear = 1'b1;
            if (pulses_done >= MAX_PULSE_CNT) begin
              phase_next   = PH_IDLE;
              cmd.done_out = 1'b1;
            end else if (status.err_ok) begin
              phase_next = PH_FINAL;
            end else begin
              // A positive error means the target lies to the left.
              turn_right_next  = !status.err_pos;
              pulses_done_next = pulses_done + 4'd1;
              phase_next       = PH_PULSE;
              cmd.drive        = DRV_CORR;
              cmd.drive_right  = !status.err_pos;
            end
          end
        end
        PH_PULSE: begin
          if (status.pulse_elapsed || status.err_ok) begin
            phase_next     = PH_SETTLE;
            cmd.time_clear = 1'b1;
          end else begin
            cmd.drive       = DRV_CORR;
            cmd.drive_right = turn_right;
          end
        end
        PH_FINAL: begin
          if (status.settle_elapsed) begin
            phase_next     = PH_IDLE;
            cmd.time_clear = 1'b1;
            cmd.done_out   = 1'b1;
          end
        end
        default: phase_next = PH_IDLE;
      endcase
      cmd.busy_out    = (phase_next != PH_IDLE);
      cmd.timeout_out = timeout_seen_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      phase        <= PH_IDLE;
      turn_right   <= 1'b0;
      braking      <= 1'b0;
      pulses_done  <= '0;
      timeout_seen <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      state        <= state_next;
      phase        <= phase_next;
      turn_right   <= turn_right_next;
      braking      <= braking_next;
      pulses_done  <= pulses_done_next;
      timeout_seen <= timeout_seen_next;
      if (step_go) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_r <= op;
    end
  end

endmodule

>>> rtl/gyro_heading_turn_controller_top.sv
`timescale 1ns / 1ps
// Top level of the gyro heading integrator and turn sequencer.
// Instantiates ghtc_ctrl and ghtc_dp; depends on ghtc_pkg.

// Each input word passes through four steps from acceptance to its result word:
// the rate times elapsed time product on the accept cycle, the scale product by the
// gyro constant, the heading and target update, and the sequencer step that
// loads the output register. These four steps go through the one multiply chain,
// so a new word is taken only after the last one has been loaded into the output
// register; if the result is not taken, the block holds in the last step.
// Configuration writes take effect on the next cycle and are meant for idle time.
module gyro_heading_turn_controller_top (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [ghtc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ghtc_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [1:0]                       op,
  input  logic signed [15:0]               gyro_z,
  input  logic [15:0]                      dt_us,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic signed [8:0]                left_drive,
  output logic signed [8:0]                right_drive,
  output logic [31:0]                      heading,
  output logic signed [31:0]               turn_error,
  output logic                             busy_res,
  output logic                             turn_done,
  output logic                             timed_out
);
  import ghtc_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  ghtc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .op        (op),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  ghtc_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .gyro_z      (gyro_z),
    .dt_us       (dt_us),
    .cmd         (cmd),
    .status      (status),
    .left_drive  (left_drive),
    .right_drive (right_drive),
    .heading     (heading),
    .turn_error  (turn_error),
    .busy_res    (busy_res),
    .turn_done   (turn_done),
    .timed_out   (timed_out)
  );

`ifndef SYNTHESIS
  // A loaded result word must be presented on the next cycle.
  a_load_shows: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |=> out_valid)
    else $error("result word loaded but not presented");

  // After a word is taken the block is busy with it for the following cycle.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input taken while a word is in progress");

  // A finished sequence never reports itself still running.
  a_done_not_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(turn_done && busy_res))
    else $error("turn reported done and busy together");

  // The two motors always turn in place: drives are opposite.
  a_drive_opposite: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (left_drive == -right_drive))
    else $error("left and right drives not opposite");
`endif

endmodule
